// ===== rtl/core/trdq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Task ready and delay queues package
// Shared sizes, codes and a helper function for the scheduler queue block.
// ----------------------------------------------------------------------------
package trdq_pkg;

   localparam int TaskSlots  = 16;
   localparam int IdWidth    = $clog2(TaskSlots);
   localparam int LinkWidth  = IdWidth + 1;
   localparam int ClassCount = 3;
   localparam int CountWidth = 5;
   localparam int TickWidth  = 32;

   localparam logic [LinkWidth-1:0] NoLink = LinkWidth'(TaskSlots);

   typedef enum logic [2:0] {
      ACT_MAKE_READY = 3'd0,
      ACT_DELAY      = 3'd1,
      ACT_REMOVE     = 3'd2,
      ACT_TICK       = 3'd3,
      ACT_SELECT     = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_IGNORED = 2'd1,
      ST_EMPTY   = 2'd2
   } status_type;

   // True when now has reached target under wrapping comparison.
   function automatic logic has_reached(input logic [TickWidth-1:0] now,
                                        input logic [TickWidth-1:0] target);
      logic [TickWidth-1:0] diff;
      diff = now - target;
      return ~diff[TickWidth-1];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/trdq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module trdq_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output      logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/core/task_ready_and_delay_queues.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Task ready and delay queues
// Three FIFO ready queues and one wake-sorted delay list over the task slots.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low. Its single
// result appears with done high for exactly one cycle and cannot be stalled.
// Each transaction runs through a small sequencer that walks the delay list
// one entry at a time, using a single wake-time RAM read port and the wrapping
// has_reached compare. make_ready first takes the task off the delay list
// when it is queued there. remove unlinks the task from its ready queue and
// walks the delay list to unlink it there, after reading the task's wake time
// when the remaining delay is reported. delay does the same unlinks and then
// a sorted insert walk, which needs a registered RAM read per entry. tick
// wakes due tasks from the head of the delay list. There is no clearing pass
// after reset: wake times of unqueued tasks are never read.
module task_ready_and_delay_queues (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output      logic                                busy,
   input  wire logic [2:0]                          req_action,
   input  wire logic [3:0]                          req_task_id,
   input  wire logic [1:0]                          req_task_kind,
   input  wire logic [31:0]                         req_delay_ticks,
   input  wire logic [31:0]                         req_current_tick,
   input  wire logic                                req_report_remaining,
   input  wire logic                                csr_we,
   input  wire logic [4:0]                          csr_wdata,
   output      logic                                done,
   output      logic [1:0]                          rsp_status,
   output      logic [3:0]                          rsp_selected_task,
   output      logic                                rsp_selected_valid,
   output      logic [31:0]                         rsp_remaining_delay,
   output      logic [4:0]                          rsp_woken_count
);
   import trdq_pkg::*;

   typedef logic [LinkWidth-1:0] link_type;
   typedef logic [IdWidth-1:0]   id_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_UNLINK_WALK,
      S_ENTER_WAIT,
      S_ENTER_CMP,
      S_TICK_WAIT,
      S_TICK_CMP,
      S_REMAIN_CMP,
      S_RESPOND
   } state_type;

   state_type state_ff;

   // Small per-slot link state in flip-flops.
   link_type rnext_ff [TaskSlots];
   link_type rprev_ff [TaskSlots];
   logic [TaskSlots-1:0] rq_ff;
   link_type head_ff [ClassCount];
   link_type tail_ff [ClassCount];
   logic [1:0] class_ff [TaskSlots];
   link_type dnext_ff [TaskSlots];
   logic [TaskSlots-1:0] dq_ff;
   link_type dhead_ff;
   logic [CountWidth-1:0] task_count_ff;

   // Transaction registers.
   action_type act_ff;
   id_type     tid_ff;
   logic [1:0] kind_ff;
   logic [TickWidth-1:0] now_ff, wake_ff;
   link_type   cur_ff, prev_ff;
   logic [1:0] status_ff;
   id_type     sel_ff;
   logic       selv_ff;
   logic [TickWidth-1:0] remain_ff;
   logic [CountWidth-1:0] woken_ff;
   logic [LinkWidth-1:0] guard_ff;

   // Wake-time RAM.
   logic   ram_we_ff;
   id_type ram_waddr_ff, ram_raddr;
   logic [TickWidth-1:0] ram_wdata_ff, ram_rdata;

   trdq_ram #(.Width(TickWidth), .Depth(TaskSlots)) u_wake_ram (
      .clock   (clock),
      .wr_en   (ram_we_ff),
      .wr_addr (ram_waddr_ff),
      .wr_data (ram_wdata_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   logic id_ok;
   assign id_ok = ({1'b0, req_task_id} < task_count_ff);

   logic [TickWidth-1:0] wake_sum;
   assign wake_sum = req_current_tick + req_delay_ticks;

   // Read address: the list entry under inspection, or the task itself.
   always_comb begin
      ram_raddr = cur_ff[IdWidth-1:0];
      if (state_ff == S_IDLE) begin
         ram_raddr = req_task_id;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      ram_we_ff    <= 1'b0;
      ram_waddr_ff <= tid_ff;
      ram_wdata_ff <= wake_ff;
      done         <= 1'b0;
      if (reset) begin
         state_ff      <= S_IDLE;
         task_count_ff <= '0;
         rq_ff         <= '0;
         dq_ff         <= '0;
         dhead_ff      <= NoLink;
         for (int i = 0; i < TaskSlots; i++) begin
            rnext_ff[i] <= NoLink;
            rprev_ff[i] <= NoLink;
            dnext_ff[i] <= NoLink;
         end
         for (int c = 0; c < ClassCount; c++) begin
            head_ff[c] <= NoLink;
            tail_ff[c] <= NoLink;
         end
      end else begin
         if (csr_we) begin
            task_count_ff <= csr_wdata;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  act_ff    <= action_type'(req_action);
                  tid_ff    <= req_task_id;
                  kind_ff   <= req_task_kind;
                  now_ff    <= req_current_tick;
                  wake_ff   <= wake_sum;
                  status_ff <= ST_IGNORED;
                  sel_ff    <= '0;
                  selv_ff   <= 1'b0;
                  remain_ff <= '0;
                  woken_ff  <= '0;
                  cur_ff    <= dhead_ff;
                  prev_ff   <= NoLink;
                  guard_ff  <= '0;
                  state_ff  <= S_RESPOND;
                  if (req_action == ACT_TICK) begin
                     status_ff <= ST_DONE;
                     state_ff  <= S_TICK_WAIT;
                  end else if (req_action == ACT_SELECT) begin
                     state_ff <= S_DISPATCH;
                  end else if (id_ok && (req_action == ACT_MAKE_READY
                               || req_action == ACT_REMOVE
                               || (req_action == ACT_DELAY && req_delay_ticks != '0))) begin
                     status_ff <= ST_DONE;
                     // Remove with report reads the task's wake time first.
                     if (req_action == ACT_REMOVE && req_report_remaining) begin
                        state_ff <= S_REMAIN_CMP;
                     end else begin
                        state_ff <= S_DISPATCH;
                     end
                  end
               end
            end
            S_REMAIN_CMP: begin
               if (dq_ff[tid_ff] && !has_reached(now_ff, ram_rdata)) begin
                  remain_ff <= ram_rdata - now_ff;
               end
               state_ff <= S_DISPATCH;
            end
            S_DISPATCH: begin
               if (act_ff == ACT_SELECT) begin
                  status_ff <= ST_EMPTY;
                  state_ff  <= S_RESPOND;
                  for (int c = ClassCount - 1; c >= 0; c--) begin
                     if (head_ff[c] != NoLink) begin
                        sel_ff <= head_ff[c][IdWidth-1:0];
                     end
                  end
                  if (head_ff[0] != NoLink || head_ff[1] != NoLink
                      || head_ff[2] != NoLink) begin
                     selv_ff   <= 1'b1;
                     status_ff <= ST_DONE;
                     state_ff  <= S_DISPATCH;
                     act_ff    <= ACT_REMOVE;
                     // The popped head becomes the target of a ready unlink.
                     for (int c = ClassCount - 1; c >= 0; c--) begin
                        if (head_ff[c] != NoLink) begin
                           tid_ff <= head_ff[c][IdWidth-1:0];
                           class_ff[head_ff[c][IdWidth-1:0]] <= 2'(c);
                        end
                     end
                  end
               end else begin
                  // Ready unlink for delay and remove.
                  if ((act_ff == ACT_DELAY || act_ff == ACT_REMOVE) && rq_ff[tid_ff]) begin
                     if (rprev_ff[tid_ff] != NoLink) begin
                        rnext_ff[rprev_ff[tid_ff][IdWidth-1:0]] <= rnext_ff[tid_ff];
                     end else begin
                        head_ff[class_ff[tid_ff]] <= rnext_ff[tid_ff];
                     end
                     if (rnext_ff[tid_ff] != NoLink) begin
                        rprev_ff[rnext_ff[tid_ff][IdWidth-1:0]] <= rprev_ff[tid_ff];
                     end else begin
                        tail_ff[class_ff[tid_ff]] <= rprev_ff[tid_ff];
                     end
                     rnext_ff[tid_ff] <= NoLink;
                     rprev_ff[tid_ff] <= NoLink;
                     rq_ff[tid_ff]    <= 1'b0;
                  end
                  cur_ff   <= dhead_ff;
                  prev_ff  <= NoLink;
                  guard_ff <= '0;
                  if (selv_ff) begin
                     state_ff <= S_RESPOND;
                  end else if (dq_ff[tid_ff]) begin
                     state_ff <= S_UNLINK_WALK;
                  end else if (act_ff == ACT_DELAY) begin
                     state_ff <= S_ENTER_WAIT;
                  end else begin
                     state_ff <= (act_ff == ACT_MAKE_READY) ? S_ENTER_WAIT : S_RESPOND;
                  end
               end
            end
            S_UNLINK_WALK: begin
               // One list entry per cycle until the task is found, the list ends or the guard runs out.
               if (cur_ff == {1'b0, tid_ff} || cur_ff == NoLink
                   || guard_ff == LinkWidth'(TaskSlots)) begin
                  if (cur_ff == {1'b0, tid_ff}) begin
                     if (prev_ff != NoLink) begin
                        dnext_ff[prev_ff[IdWidth-1:0]] <= dnext_ff[tid_ff];
                     end else begin
                        dhead_ff <= dnext_ff[tid_ff];
                     end
                  end
                  dnext_ff[tid_ff] <= NoLink;
                  dq_ff[tid_ff]    <= 1'b0;
                  prev_ff          <= NoLink;
                  guard_ff         <= '0;
                  if (cur_ff == {1'b0, tid_ff} && prev_ff == NoLink) begin
                     cur_ff <= dnext_ff[tid_ff];
                  end else begin
                     cur_ff <= dhead_ff;
                  end
                  state_ff <= (act_ff == ACT_REMOVE) ? S_RESPOND : S_ENTER_WAIT;
               end else begin
                  prev_ff  <= cur_ff;
                  cur_ff   <= dnext_ff[cur_ff[IdWidth-1:0]];
                  guard_ff <= guard_ff + 1'b1;
               end
            end
            S_ENTER_WAIT: begin
               if (act_ff == ACT_MAKE_READY) begin
                  if (!rq_ff[tid_ff] && kind_ff != 2'd3) begin
                     class_ff[tid_ff] <= kind_ff;
                     rnext_ff[tid_ff] <= NoLink;
                     rprev_ff[tid_ff] <= tail_ff[kind_ff];
                     if (tail_ff[kind_ff] != NoLink) begin
                        rnext_ff[tail_ff[kind_ff][IdWidth-1:0]] <= {1'b0, tid_ff};
                     end else begin
                        head_ff[kind_ff] <= {1'b0, tid_ff};
                     end
                     tail_ff[kind_ff] <= {1'b0, tid_ff};
                     rq_ff[tid_ff]    <= 1'b1;
                  end else begin
                     status_ff <= ST_IGNORED;
                  end
                  state_ff <= S_RESPOND;
               end else if (cur_ff == NoLink || guard_ff == LinkWidth'(TaskSlots)) begin
                  dnext_ff[tid_ff] <= cur_ff;
                  dq_ff[tid_ff]    <= 1'b1;
                  ram_we_ff        <= 1'b1;
                  if (prev_ff != NoLink) begin
                     dnext_ff[prev_ff[IdWidth-1:0]] <= {1'b0, tid_ff};
                  end else begin
                     dhead_ff <= {1'b0, tid_ff};
                  end
                  state_ff <= S_RESPOND;
               end else begin
                  state_ff <= S_ENTER_CMP;
               end
            end
            S_ENTER_CMP: begin
               if (has_reached(ram_rdata, wake_ff)) begin
                  guard_ff <= LinkWidth'(TaskSlots);
               end else begin
                  prev_ff  <= cur_ff;
                  cur_ff   <= dnext_ff[cur_ff[IdWidth-1:0]];
                  guard_ff <= guard_ff + 1'b1;
               end
               state_ff <= S_ENTER_WAIT;
            end
            S_TICK_WAIT: begin
               cur_ff <= dhead_ff;
               if (dhead_ff == NoLink || guard_ff == LinkWidth'(TaskSlots)) begin
                  state_ff <= S_RESPOND;
               end else if (cur_ff == dhead_ff) begin
                  state_ff <= S_TICK_CMP;
               end
            end
            S_TICK_CMP: begin
               if (!has_reached(now_ff, ram_rdata)) begin
                  state_ff <= S_RESPOND;
               end else begin
                  dhead_ff         <= dnext_ff[cur_ff[IdWidth-1:0]];
                  dnext_ff[cur_ff[IdWidth-1:0]] <= NoLink;
                  dq_ff[cur_ff[IdWidth-1:0]]    <= 1'b0;
                  guard_ff <= guard_ff + 1'b1;
                  if (cur_ff < LinkWidth'(task_count_ff) && !rq_ff[cur_ff[IdWidth-1:0]]
                      && class_ff[cur_ff[IdWidth-1:0]] != 2'd3) begin
                     rnext_ff[cur_ff[IdWidth-1:0]] <= NoLink;
                     rprev_ff[cur_ff[IdWidth-1:0]] <=
                        tail_ff[class_ff[cur_ff[IdWidth-1:0]]];
                     if (tail_ff[class_ff[cur_ff[IdWidth-1:0]]] != NoLink) begin
                        rnext_ff[tail_ff[class_ff[cur_ff[IdWidth-1:0]]][IdWidth-1:0]]
                           <= cur_ff;
                     end else begin
                        head_ff[class_ff[cur_ff[IdWidth-1:0]]] <= cur_ff;
                     end
                     tail_ff[class_ff[cur_ff[IdWidth-1:0]]] <= cur_ff;
                     rq_ff[cur_ff[IdWidth-1:0]] <= 1'b1;
                     woken_ff <= woken_ff + 1'b1;
                  end
                  state_ff <= S_TICK_WAIT;
               end
            end
            S_RESPOND: begin
               done                <= 1'b1;
               rsp_status          <= status_ff;
               rsp_selected_task   <= sel_ff;
               rsp_selected_valid  <= selv_ff;
               rsp_remaining_delay <= remain_ff;
               rsp_woken_count     <= woken_ff;
               state_ff            <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // A result is only produced by the final sequencer step.
   assert property (@(posedge clock) disable iff (reset)
      done |-> $past(state_ff) == S_RESPOND)
      else $error("result without respond step");

   // A popped task is always reported as valid with done status.
   assert property (@(posedge clock) disable iff (reset)
      (done && rsp_selected_valid) |-> rsp_status == ST_DONE)
      else $error("selected task with bad status");

   // Queue head and tail agree on emptiness for class 0 while idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((head_ff[0] == NoLink) == (tail_ff[0] == NoLink)))
      else $error("application queue head and tail disagree");

   // The block is busy in the cycle after accepting a transaction.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("not busy after accept");

endmodule
`default_nettype wire
